### design/c8alu_pkg.sv
package c8alu_pkg;

	localparam int unsigned OpWidth = 5;

	localparam logic [OpWidth-1:0] OP_ADD   = 5'd0;
	localparam logic [OpWidth-1:0] OP_ADC   = 5'd1;
	localparam logic [OpWidth-1:0] OP_SUB   = 5'd2;
	localparam logic [OpWidth-1:0] OP_SBC   = 5'd3;
	localparam logic [OpWidth-1:0] OP_AND   = 5'd4;
	localparam logic [OpWidth-1:0] OP_XOR   = 5'd5;
	localparam logic [OpWidth-1:0] OP_OR    = 5'd6;
	localparam logic [OpWidth-1:0] OP_CP    = 5'd7;
	localparam logic [OpWidth-1:0] OP_INC   = 5'd8;
	localparam logic [OpWidth-1:0] OP_DEC   = 5'd9;
	localparam logic [OpWidth-1:0] OP_NEG   = 5'd10;
	localparam logic [OpWidth-1:0] OP_DAA   = 5'd11;
	localparam logic [OpWidth-1:0] OP_CPL   = 5'd12;
	localparam logic [OpWidth-1:0] OP_CCF   = 5'd13;
	localparam logic [OpWidth-1:0] OP_SCF   = 5'd14;
	localparam logic [OpWidth-1:0] OP_ADD16 = 5'd15;
	localparam logic [OpWidth-1:0] OP_ADC16 = 5'd16;
	localparam logic [OpWidth-1:0] OP_SBC16 = 5'd17;

	// flag bit positions
	localparam int unsigned FL_S  = 7;
	localparam int unsigned FL_Z  = 6;
	localparam int unsigned FL_H  = 4;
	localparam int unsigned FL_PV = 2;
	localparam int unsigned FL_N  = 1;
	localparam int unsigned FL_C  = 0;

	localparam logic [7:0] FL_KEEP = 8'hD7;

	typedef struct packed {
		logic [OpWidth-1:0] op;
		logic [7:0]         acc_in;
		logic [7:0]         operand8;
		logic [7:0]         flags_in;
		logic [15:0]        hl_in;
		logic [15:0]        operand16;
	} req_word_t;

	typedef struct packed {
		logic [7:0]  result8;
		logic [15:0] result16;
		logic [7:0]  flags_out;
	} rsp_word_t;

	function automatic logic [7:0] mk_flags(input logic s, input logic z, input logic h,
		input logic pv, input logic n, input logic c);
		mk_flags = {s, z, 1'b0, h, 1'b0, pv, n, c};
	endfunction

endpackage

### design/cpu8_alu_with_flags.sv
// 8-bit ALU with flag byte. A request word carries the operation code, the accumulator,
// an 8-bit operand, the incoming flags, HL and a 16-bit operand; the response word
// carries the 8-bit result, the 16-bit result and the new flags (S7 Z6 H4 P/V2 N1 C0,
// bits 5 and 3 always zero). One word can be accepted every cycle while responses are
// taken. An accepted word lands in the input register, and one pass through the ALU
// logic fills the output register, from which the response word is presented. When the
// response is not taken the output register holds, the input register takes one more
// word and then holds as well, so the block holds at most two words in flight.
// Undefined operation codes pass the accumulator and HL through and keep the flags.
module cpu8_alu_with_flags (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  c8alu_pkg::req_word_t req_word,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output c8alu_pkg::rsp_word_t rsp_word
);
	import c8alu_pkg::*;

	logic      valid_s1, valid_s2;
	req_word_t word_s1;
	rsp_word_t res_s2;
	rsp_word_t alu_res;
	logic      adv_s2;

	assign adv_s2    = !valid_s2 || rsp_ready;
	assign req_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			word_s1 <= req_word;
		end
		if (valid_s1 && adv_s2) begin
			res_s2 <= alu_res;
		end
	end

	c8alu_core u_core (
		.item (word_s1),
		.res  (alu_res)
	);

	assign rsp_valid = valid_s2;
	assign rsp_word  = res_s2;

	// a response only appears after a word sat in the input register
	a_rsp_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("response word without a source word");

	// an empty output stage always takes the pending word
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("input word not moved to output stage");

	// compare keeps the accumulator
	a_cp_keeps_acc: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 && (word_s1.op == OP_CP) |=> res_s2.result8 == $past(word_s1.acc_in))
		else $error("compare changed the accumulator");

endmodule

### design/c8alu_core.sv
module c8alu_core (
	input  c8alu_pkg::req_word_t item,
	output c8alu_pkg::rsp_word_t res
);
	import c8alu_pkg::*;

	logic [7:0]  a, b, fi;
	logic [15:0] hl, w;
	logic        cin, cin8, cin16;

	logic [8:0]  add_s, sub_d;
	logic [4:0]  add_h, sub_h;
	logic [7:0]  add_r, sub_r;
	logic [7:0]  add_f, sub_f;

	logic [7:0]  inc_r, dec_r, neg_r, and_r, xor_r, or_r;

	logic        lo_gt9, big;
	logic [7:0]  corr, daa_r;
	logic        daa_h;

	logic [16:0] add16_s, sub16_d;
	logic [12:0] add16_h, sub16_h;

	assign a     = item.acc_in;
	assign b     = item.operand8;
	assign fi    = item.flags_in;
	assign hl    = item.hl_in;
	assign w     = item.operand16;
	assign cin   = fi[FL_C];
	assign cin8  = ((item.op == OP_ADC) || (item.op == OP_SBC)) && cin;
	assign cin16 = (item.op == OP_ADC16) && cin;

	// 8-bit adder and subtractor
	assign add_s = {1'b0, a} + {1'b0, b} + {8'b0, cin8};
	assign add_h = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin8};
	assign add_r = add_s[7:0];
	assign add_f = mk_flags(add_r[7], add_r == 8'h00, add_h[4],
		~(a[7] ^ b[7]) & (a[7] ^ add_r[7]), 1'b0, add_s[8]);

	assign sub_d = {1'b0, a} - {1'b0, b} - {8'b0, cin8};
	assign sub_h = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cin8};
	assign sub_r = sub_d[7:0];
	assign sub_f = mk_flags(sub_r[7], sub_r == 8'h00, sub_h[4],
		(a[7] ^ b[7]) & (a[7] ^ sub_r[7]), 1'b1, sub_d[8]);

	assign inc_r = b + 8'd1;
	assign dec_r = b - 8'd1;
	assign neg_r = (~a) + 8'd1;
	assign and_r = a & b;
	assign xor_r = a ^ b;
	assign or_r  = a | b;

	// decimal adjust
	assign lo_gt9 = a[3:0] > 4'd9;
	assign big    = cin || (a > 8'h99);
	assign corr   = {1'b0, big, big, 2'b00, fi[FL_H] || lo_gt9, fi[FL_H] || lo_gt9, 1'b0};
	assign daa_r  = fi[FL_N] ? (a - corr) : (a + corr);
	assign daa_h  = fi[FL_N] ? (fi[FL_H] && (a[3:0] < 4'd6)) : lo_gt9;

	// 16-bit adder and subtractor
	assign add16_s = {1'b0, hl} + {1'b0, w} + {16'b0, cin16};
	assign add16_h = {1'b0, hl[11:0]} + {1'b0, w[11:0]} + {12'b0, cin16};
	assign sub16_d = {1'b0, hl} - {1'b0, w} - {16'b0, cin};
	assign sub16_h = {1'b0, hl[11:0]} - {1'b0, w[11:0]} - {12'b0, cin};

	always_comb begin
		res.result8   = a;
		res.result16  = hl;
		res.flags_out = fi & FL_KEEP;
		unique case (item.op)
			OP_ADD, OP_ADC: begin
				res.result8   = add_r;
				res.flags_out = add_f;
			end
			OP_SUB, OP_SBC: begin
				res.result8   = sub_r;
				res.flags_out = sub_f;
			end
			OP_CP: begin
				res.flags_out = sub_f;
			end
			OP_AND: begin
				res.result8   = and_r;
				res.flags_out = mk_flags(and_r[7], and_r == 8'h00, 1'b1, ~^and_r, 1'b0, 1'b0);
			end
			OP_XOR: begin
				res.result8   = xor_r;
				res.flags_out = mk_flags(xor_r[7], xor_r == 8'h00, 1'b0, ~^xor_r, 1'b0, 1'b0);
			end
			OP_OR: begin
				res.result8   = or_r;
				res.flags_out = mk_flags(or_r[7], or_r == 8'h00, 1'b0, ~^or_r, 1'b0, 1'b0);
			end
			OP_INC: begin
				res.result8   = inc_r;
				res.flags_out = mk_flags(inc_r[7], inc_r == 8'h00, inc_r[3:0] == 4'h0,
					inc_r == 8'h80, 1'b0, cin);
			end
			OP_DEC: begin
				res.result8   = dec_r;
				res.flags_out = mk_flags(dec_r[7], dec_r == 8'h00, dec_r[3:0] == 4'hF,
					dec_r == 8'h7F, 1'b1, cin);
			end
			OP_NEG: begin
				res.result8   = neg_r;
				res.flags_out = mk_flags(neg_r[7], neg_r == 8'h00, a[3:0] != 4'h0,
					a == 8'h80, 1'b1, a != 8'h00);
			end
			OP_DAA: begin
				res.result8   = daa_r;
				res.flags_out = mk_flags(daa_r[7], daa_r == 8'h00, daa_h, ~^daa_r,
					fi[FL_N], big);
			end
			OP_CPL: begin
				res.result8   = ~a;
				res.flags_out = mk_flags(fi[FL_S], fi[FL_Z], 1'b1, fi[FL_PV], 1'b1, cin);
			end
			OP_CCF: begin
				res.flags_out = mk_flags(fi[FL_S], fi[FL_Z], cin, fi[FL_PV], 1'b0, ~cin);
			end
			OP_SCF: begin
				res.flags_out = mk_flags(fi[FL_S], fi[FL_Z], 1'b0, fi[FL_PV], 1'b0, 1'b1);
			end
			OP_ADD16: begin
				res.result16  = add16_s[15:0];
				res.flags_out = mk_flags(fi[FL_S], fi[FL_Z], add16_h[12], fi[FL_PV], 1'b0,
					add16_s[16]);
			end
			OP_ADC16: begin
				res.result16  = add16_s[15:0];
				res.flags_out = mk_flags(add16_s[15], add16_s[15:0] == 16'h0000, add16_h[12],
					~(hl[15] ^ w[15]) & (hl[15] ^ add16_s[15]), 1'b0, add16_s[16]);
			end
			OP_SBC16: begin
				res.result16  = sub16_d[15:0];
				res.flags_out = mk_flags(sub16_d[15], sub16_d[15:0] == 16'h0000, sub16_h[12],
					(hl[15] ^ w[15]) & (hl[15] ^ sub16_d[15]), 1'b1, sub16_d[16]);
			end
			default: begin
			end
		endcase
	end

endmodule
